FILE: rtl/ntc_pkg.sv
package ntc_pkg;

  localparam int SAMPLE_W = 12;
  localparam int TEMP_W   = 16;
  localparam int STATUS_W = 2;
  localparam int DIV_W    = 50;

  localparam logic [11:0] FULL_SCALE = 12'd4095;
  localparam logic [31:0] LN2_Q32    = 32'd2977044472;
  localparam logic [DIV_W-1:0] SCALE = DIV_W'(100) << 40;
  localparam logic signed [50:0] KELVIN_CENTI = 51'sd27315;
  localparam logic signed [TEMP_W-1:0] TEMP_INVALID = -16'sd27315;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX     = 16'sd32767;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN     = -16'sd32768;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  // register indexes
  localparam logic [1:0] REG_SERIES  = 2'd0;
  localparam logic [1:0] REG_NOMINAL = 2'd1;
  localparam logic [1:0] REG_BETA    = 2'd2;
  localparam logic [1:0] REG_T0      = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_DIV_END,
    S_MUL_NUM,
    S_MUL_DEN,
    S_LN_LOAD,
    S_LN_NORM,
    S_LN_SQ,
    S_LN_STEP,
    S_LN_SCALE,
    S_LN_DONE,
    S_INV,
    S_SAT,
    S_RESULT
  } state_t;

  typedef enum logic [1:0] {
    PH_AVG,
    PH_T1,
    PH_T2,
    PH_TC
  } div_phase_t;

endpackage

FILE: rtl/ntc_in_if.sv
interface ntc_in_if;
  logic                          valid;
  logic                          ready;
  logic [ntc_pkg::SAMPLE_W-1:0]  sample;
  logic                          sample_ok;

  modport source(output valid, sample, sample_ok, input ready);
  modport sink(input valid, sample, sample_ok, output ready);
endinterface

FILE: rtl/ntc_out_if.sv
interface ntc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [ntc_pkg::TEMP_W-1:0]   temperature_centi;
  logic [ntc_pkg::STATUS_W-1:0]        status;

  modport source(output valid, temperature_centi, status, input ready);
  modport sink(input valid, temperature_centi, status, output ready);
endinterface

FILE: rtl/ntc_thermistor_temperature.sv
// NTC thermistor temperature from groups of ADC samples (beta equation).
// Channel samples takes one 12-bit ADC word with a success flag per handshake;
// every word counts toward a group, only successful ones add to the sum.
// Channel results gives one word per completed group: temperature in
// hundredths of a degree Celsius and a status code (ok, zero or full-scale average).
// The APB port writes and reads the four calibration registers at 4*index.
// A word that does not complete a group is taken while the sequencer is idle.
// The word that completes a group starts a sequencer built around one
// bit-serial restoring divider (up to four divisions per group), one
// registered 32x32 multiplier, and a log unit that normalizes one bit per
// cycle and squares the mantissa for 20 fraction bits. Samples is held not
// ready from the last word of a group until the result leaves the sequencer.
// The result sits in an output register; if the receiver stalls, the next
// result waits in the sequencer and samples stays not ready until it is taken.
// Reset clears the sum, count and sequencer and restores register defaults.
module ntc_thermistor_temperature #(
  parameter int SAMPLES_PER_RESULT = 5
) (
  input  logic        clk,
  input  logic        rst,
  ntc_in_if.sink      samples,
  ntc_out_if.source   results,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CNT_W = (SAMPLES_PER_RESULT > 1) ? $clog2(SAMPLES_PER_RESULT) : 1;
  localparam int SUM_W = ntc_pkg::SAMPLE_W + $clog2(SAMPLES_PER_RESULT + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_RESULT - 1);
  localparam int DW = ntc_pkg::DIV_W;

  // configuration registers
  logic [19:0]        series_resistance;
  logic [19:0]        nominal_resistance;
  logic [15:0]        beta_factor;
  logic signed [14:0] nominal_temp_centi;

  logic cfg_write;
  assign cfg_write = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      series_resistance  <= 20'd10000;
      nominal_resistance <= 20'd10000;
      beta_factor        <= 16'd3950;
      nominal_temp_centi <= 15'sd2500;
    end else if (cfg_write) begin
      case (paddr[3:2])
        ntc_pkg::REG_SERIES:  series_resistance  <= pwdata[19:0];
        ntc_pkg::REG_NOMINAL: nominal_resistance <= pwdata[19:0];
        ntc_pkg::REG_BETA:    beta_factor        <= pwdata[15:0];
        ntc_pkg::REG_T0:      nominal_temp_centi <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[3:2])
      ntc_pkg::REG_SERIES:  prdata = {12'd0, series_resistance};
      ntc_pkg::REG_NOMINAL: prdata = {12'd0, nominal_resistance};
      ntc_pkg::REG_BETA:    prdata = {16'd0, beta_factor};
      ntc_pkg::REG_T0:      prdata = {{17{nominal_temp_centi[14]}}, nominal_temp_centi};
      default:              prdata = 32'd0;
    endcase
  end

  // sequencer and datapath registers
  ntc_pkg::state_t     state, state_next;
  ntc_pkg::div_phase_t phase;
  logic [SUM_W-1:0]    sum;
  logic [CNT_W-1:0]    count;
  logic [11:0]         avg;
  logic [31:0]         num_r;
  logic [31:0]         den_r;
  logic [63:0]         prod;
  logic [31:0]         lx;
  logic [4:0]          lk;
  logic [30:0]         lm;
  logic [24:0]         log2v;
  logic [4:0]          lit;
  logic                ln_sel;
  logic [20:0]         lnum;
  logic [DW-1:0]       div_rem, div_quo, div_den;
  logic [5:0]          div_cnt;
  logic                neg;
  logic signed [50:0]  term1;
  logic signed [50:0]  inv_t;
  logic signed [50:0]  tc;
  logic signed [15:0]  res_temp;
  logic [1:0]          res_status;
  logic                out_valid;
  logic signed [15:0]  out_temp;
  logic [1:0]          out_status;

  logic accept;
  assign samples.ready = (state == ntc_pkg::S_IDLE);
  assign accept = samples.valid && samples.ready;

  logic [SUM_W-1:0] sum_total;
  assign sum_total = sum + (samples.sample_ok ? SUM_W'(samples.sample) : SUM_W'(0));

  // divider step
  logic [DW:0] trial;
  logic        trial_ge;
  assign trial    = {div_rem, div_quo[DW-1]};
  assign trial_ge = trial >= {1'b0, div_den};

  // shared multiplier operands
  logic [31:0] mul_a, mul_b;
  always_comb begin
    case (state)
      ntc_pkg::S_MUL_NUM: begin
        mul_a = 32'(series_resistance);
        mul_b = 32'(avg);
      end
      ntc_pkg::S_MUL_DEN: begin
        mul_a = 32'(nominal_resistance);
        mul_b = 32'(ntc_pkg::FULL_SCALE - avg);
      end
      ntc_pkg::S_LN_SQ: begin
        mul_a = 32'(lm);
        mul_b = 32'(lm);
      end
      ntc_pkg::S_LN_SCALE: begin
        mul_a = 32'(log2v);
        mul_b = ntc_pkg::LN2_Q32;
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  // log helpers
  logic [31:0] msq;
  logic [63:0] ln_sum;
  logic [20:0] lnv;
  logic signed [21:0] l_val;
  logic [20:0] l_mag;
  assign msq    = prod[61:30];
  assign ln_sum = prod + (64'd1 << 35);
  assign lnv    = ln_sum[56:36];
  assign l_val  = $signed({1'b0, lnum}) - $signed({1'b0, lnv});
  assign l_mag  = l_val[21] ? 21'(-l_val) : l_val[20:0];

  // nominal temperature in centikelvin
  logic signed [17:0] t0k;
  logic [16:0]        t0k_u;
  assign t0k   = 18'(nominal_temp_centi) + 18'sd27315;
  assign t0k_u = t0k[16:0];

  logic signed [50:0] quo_s;
  logic signed [50:0] inv_sum;
  logic [DW-1:0]      inv_mag;
  logic signed [50:0] t_val;
  assign quo_s   = $signed({1'b0, div_quo});
  assign inv_sum = term1 + quo_s;
  assign inv_mag = inv_t[50] ? DW'(-inv_t) : inv_t[DW-1:0];
  assign t_val   = tc - ntc_pkg::KELVIN_CENTI;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ntc_pkg::S_IDLE:
        if (accept && count == CNT_LAST) state_next = ntc_pkg::S_DIV;
      ntc_pkg::S_DIV:
        if (div_cnt == 6'(DW - 1)) state_next = ntc_pkg::S_DIV_END;
      ntc_pkg::S_DIV_END:
        case (phase)
          ntc_pkg::PH_AVG:
            if (div_quo == '0 || div_quo[11:0] == ntc_pkg::FULL_SCALE)
              state_next = ntc_pkg::S_RESULT;
            else
              state_next = ntc_pkg::S_MUL_NUM;
          ntc_pkg::PH_T1: state_next = ntc_pkg::S_DIV;
          ntc_pkg::PH_T2: state_next = ntc_pkg::S_INV;
          ntc_pkg::PH_TC: state_next = ntc_pkg::S_SAT;
          default:        state_next = ntc_pkg::S_IDLE;
        endcase
      ntc_pkg::S_MUL_NUM: state_next = ntc_pkg::S_MUL_DEN;
      ntc_pkg::S_MUL_DEN: state_next = ntc_pkg::S_LN_LOAD;
      ntc_pkg::S_LN_LOAD:
        if (num_r == 32'd0 || prod[31:0] == 32'd0) state_next = ntc_pkg::S_RESULT;
        else state_next = ntc_pkg::S_LN_NORM;
      ntc_pkg::S_LN_NORM:
        if (lx[31]) state_next = ntc_pkg::S_LN_SQ;
      ntc_pkg::S_LN_SQ: state_next = ntc_pkg::S_LN_STEP;
      ntc_pkg::S_LN_STEP:
        state_next = (lit == 5'd0) ? ntc_pkg::S_LN_SCALE : ntc_pkg::S_LN_SQ;
      ntc_pkg::S_LN_SCALE: state_next = ntc_pkg::S_LN_DONE;
      ntc_pkg::S_LN_DONE:
        state_next = ln_sel ? ntc_pkg::S_DIV : ntc_pkg::S_LN_NORM;
      ntc_pkg::S_INV:
        state_next = (inv_t == '0) ? ntc_pkg::S_RESULT : ntc_pkg::S_DIV;
      ntc_pkg::S_SAT: state_next = ntc_pkg::S_RESULT;
      ntc_pkg::S_RESULT:
        if (!out_valid || results.ready) state_next = ntc_pkg::S_IDLE;
      default: state_next = ntc_pkg::S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ntc_pkg::S_IDLE;
    else state <= state_next;
  end

  // sample accumulation
  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      count <= '0;
    end else if (accept) begin
      if (count == CNT_LAST) begin
        sum   <= '0;
        count <= '0;
      end else begin
        sum   <= sum_total;
        count <= count + CNT_W'(1);
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      ntc_pkg::S_IDLE: begin
        div_quo <= DW'(sum_total);
        div_rem <= '0;
        div_den <= DW'(SAMPLES_PER_RESULT);
        div_cnt <= '0;
        phase   <= ntc_pkg::PH_AVG;
      end
      ntc_pkg::S_DIV: begin
        div_rem <= trial_ge ? DW'(trial - {1'b0, div_den}) : trial[DW-1:0];
        div_quo <= {div_quo[DW-2:0], trial_ge};
        div_cnt <= div_cnt + 6'd1;
      end
      ntc_pkg::S_DIV_END: begin
        div_rem <= '0;
        div_cnt <= '0;
        case (phase)
          ntc_pkg::PH_AVG: begin
            avg <= div_quo[11:0];
            res_temp <= ntc_pkg::TEMP_INVALID;
            res_status <= (div_quo == '0) ? ntc_pkg::STATUS_ZERO : ntc_pkg::STATUS_FULL;
          end
          ntc_pkg::PH_T1: begin
            term1   <= neg ? -quo_s : quo_s;
            div_quo <= ntc_pkg::SCALE + DW'(t0k_u >> 1);
            div_den <= DW'(t0k_u);
            phase   <= ntc_pkg::PH_T2;
          end
          ntc_pkg::PH_T2: inv_t <= inv_sum;
          ntc_pkg::PH_TC: tc <= neg ? -quo_s : quo_s;
          default: ;
        endcase
      end
      ntc_pkg::S_MUL_DEN: num_r <= prod[31:0];
      ntc_pkg::S_LN_LOAD: begin
        den_r      <= prod[31:0];
        lx         <= num_r;
        lk         <= 5'd31;
        ln_sel     <= 1'b0;
        res_temp   <= ntc_pkg::TEMP_INVALID;
        res_status <= ntc_pkg::STATUS_OK;
      end
      ntc_pkg::S_LN_NORM: begin
        if (lx[31]) begin
          lm    <= lx[31:1];
          log2v <= {lk, 20'd0};
          lit   <= 5'd19;
        end else begin
          lx <= lx << 1;
          lk <= lk - 5'd1;
        end
      end
      ntc_pkg::S_LN_STEP: begin
        if (msq[31]) begin
          lm <= msq[31:1];
          log2v[lit] <= 1'b1;
        end else begin
          lm <= msq[30:0];
        end
        lit <= lit - 5'd1;
      end
      ntc_pkg::S_LN_DONE: begin
        if (!ln_sel) begin
          lnum   <= lnv;
          lx     <= den_r;
          lk     <= 5'd31;
          ln_sel <= 1'b1;
        end else begin
          neg     <= l_val[21];
          div_quo <= DW'({l_mag, 24'd0}) + DW'(beta_factor >> 1);
          div_den <= (beta_factor == 16'd0) ? DW'(1) : DW'(beta_factor);
          phase   <= ntc_pkg::PH_T1;
        end
      end
      ntc_pkg::S_INV: begin
        neg        <= inv_t[50];
        div_quo    <= ntc_pkg::SCALE + (inv_mag >> 1);
        div_den    <= inv_mag;
        phase      <= ntc_pkg::PH_TC;
        res_temp   <= ntc_pkg::TEMP_MAX;
        res_status <= ntc_pkg::STATUS_OK;
      end
      ntc_pkg::S_SAT: begin
        if (t_val > 51'(ntc_pkg::TEMP_MAX)) res_temp <= ntc_pkg::TEMP_MAX;
        else if (t_val < 51'(ntc_pkg::TEMP_MIN)) res_temp <= ntc_pkg::TEMP_MIN;
        else res_temp <= t_val[15:0];
        res_status <= ntc_pkg::STATUS_OK;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ntc_pkg::S_RESULT && (!out_valid || results.ready)) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ntc_pkg::S_RESULT && (!out_valid || results.ready)) begin
      out_temp   <= res_temp;
      out_status <= res_status;
    end
  end

  assign results.valid             = out_valid;
  assign results.temperature_centi = out_temp;
  assign results.status            = out_status;

endmodule

FILE: tb/ntc_temp_checker.sv
module ntc_temp_checker (
  input  logic        clk,
  input  logic        rst,
  ntc_in_if           samples,
  ntc_out_if          results,
  input  logic [19:0] series_r,
  input  logic [19:0] nominal_r,
  input  logic [15:0] beta,
  input  logic signed [14:0] t0_centi,
  output int          errors,
  output int          pending,
  output int          groups_seen
);

  typedef struct packed {
    logic signed [ntc_pkg::TEMP_W-1:0] temp;
    logic [ntc_pkg::STATUS_W-1:0]      status;
  } reading_t;

  reading_t    expected_readings[$];
  logic [31:0] group_sum;
  int          group_count;

  // natural log of x in q16 via log2 with 20 fraction bits
  function automatic longint ln_q16(longint unsigned x);
    int unsigned    k;
    longint unsigned m;
    longint unsigned lg;
    k = 0;
    while (k < 63 && (x >> (k + 1)) != 0) k++;
    if (k <= 30) m = x << (30 - k);
    else m = x >> (k - 30);
    lg = longint'(k) << 20;
    for (int i = 19; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        lg = lg | (64'd1 << i);
      end
    end
    return longint'((lg * 64'd2977044472 + (64'd1 << 35)) >> 36);
  endfunction

  function automatic longint round_div(longint num, longint unsigned den);
    longint unsigned mag;
    longint unsigned q;
    mag = num < 0 ? -num : num;
    q = (mag + den / 2) / den;
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  // beta-equation temperature in centidegrees for a nonzero, non-full average
  function automatic logic signed [15:0] beta_temp(logic [11:0] avg);
    longint unsigned num;
    longint unsigned den;
    longint unsigned b;
    longint          scale;
    longint          l;
    longint          inv_t;
    longint          t;
    num = longint'(series_r) * avg;
    den = longint'(12'd4095 - avg) * nominal_r;
    b = beta == 0 ? 1 : beta;
    scale = 64'd100 << 40;
    if (num == 0 || den == 0) return ntc_pkg::TEMP_INVALID;
    l = ln_q16(num) - ln_q16(den);
    inv_t = round_div(l * (64'sd1 << 24), b)
          + round_div(scale, longint'(int'(t0_centi) + 27315));
    if (inv_t == 0) return ntc_pkg::TEMP_MAX;
    t = round_div(inv_t < 0 ? -scale : scale, inv_t < 0 ? -inv_t : inv_t) - 27315;
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    return t[15:0];
  endfunction

  // group accumulation and output comparison
  always @(posedge clk) begin
    reading_t r;
    logic [11:0] avg;
    if (rst) begin
      group_sum <= 0;
      group_count = 0;
      errors = 0;
      groups_seen = 0;
      expected_readings.delete();
    end else begin
      if (samples.valid && samples.ready) begin
        logic [31:0] s;
        s = group_sum + (samples.sample_ok ? samples.sample : 0);
        group_count++;
        if (group_count >= 5) begin
          avg = s / 5;
          if (avg == 0) begin
            r.status = ntc_pkg::STATUS_ZERO;
            r.temp = ntc_pkg::TEMP_INVALID;
          end else if (avg >= ntc_pkg::FULL_SCALE) begin
            r.status = ntc_pkg::STATUS_FULL;
            r.temp = ntc_pkg::TEMP_INVALID;
          end else begin
            r.status = ntc_pkg::STATUS_OK;
            r.temp = beta_temp(avg);
          end
          expected_readings.push_back(r);
          group_count = 0;
          group_sum <= 0;
        end else begin
          group_sum <= s;
        end
      end
      if (results.valid && results.ready) begin
        groups_seen++;
        if (expected_readings.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word: temp %0d status %0d",
                                     results.temperature_centi, results.status);
        end else begin
          r = expected_readings.pop_front();
          if (r.temp !== results.temperature_centi || r.status !== results.status) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected temp %0d status %0d, got temp %0d status %0d",
                       r.temp, r.status, results.temperature_centi, results.status);
          end
        end
      end
    end
    pending = expected_readings.size();
  end

endmodule

FILE: tb/tb_ntc_thermistor_temperature.sv
module tb_ntc_thermistor_temperature;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          errors;
  int          pending;
  int          groups_seen;
  int          in_idle_pct;
  int          out_stall_pct;
  int          words_sent;

  logic [19:0] series_r;
  logic [19:0] nominal_r;
  logic [15:0] beta;
  logic signed [14:0] t0_centi;

  ntc_in_if  samples ();
  ntc_out_if results ();

  ntc_thermistor_temperature DUT (
    .clk(clk), .rst(rst), .samples(samples), .results(results),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ntc_temp_checker checker_inst (
    .clk(clk), .rst(rst), .samples(samples), .results(results),
    .series_r(series_r), .nominal_r(nominal_r), .beta(beta), .t0_centi(t0_centi),
    .errors(errors), .pending(pending), .groups_seen(groups_seen)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

  // receiver stalls at random
  always @(posedge clk) begin
    if (rst) results.ready <= 1'b0;
    else results.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // apb write: setup then access, bus left selected for the next write
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      ntc_pkg::REG_SERIES:  series_r = val[19:0];
      ntc_pkg::REG_NOMINAL: nominal_r = val[19:0];
      ntc_pkg::REG_BETA:    beta = val[15:0];
      default:              t0_centi = val[14:0];
    endcase
  endtask

  task automatic set_config(logic [19:0] s, logic [19:0] n, logic [15:0] b,
                            logic signed [14:0] t);
    write_reg(ntc_pkg::REG_SERIES, {12'd0, s});
    write_reg(ntc_pkg::REG_NOMINAL, {12'd0, n});
    write_reg(ntc_pkg::REG_BETA, {16'd0, b});
    write_reg(ntc_pkg::REG_T0, {{17{t[14]}}, t});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // send one word, idling first at random
  task automatic send_word(logic [11:0] s, logic ok);
    while ($urandom_range(99) < in_idle_pct) begin
      samples.valid <= 1'b0;
      @(posedge clk);
    end
    samples.valid <= 1'b1;
    samples.sample <= s;
    samples.sample_ok <= ok;
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_group(logic [11:0] s, logic ok);
    for (int i = 0; i < 5; i++) send_word(s, ok);
  endtask

  // wait for all expected words, then let the sequencer settle
  task automatic drain();
    samples.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic random_words(int n);
    logic [11:0] s;
    int mode;
    for (int i = 0; i < n; i++) begin
      mode = $urandom_range(9);
      if (mode == 0) s = '0;
      else if (mode == 1) s = 12'hFFF;
      else if (mode < 5) s = 12'($urandom_range(4095));
      else s = 12'($urandom_range(3500, 500));
      send_word(s, $urandom_range(15) != 0);
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    samples.valid = 1'b0;
    samples.sample = '0;
    samples.sample_ok = 1'b0;
    series_r = 20'd10000;
    nominal_r = 20'd10000;
    beta = 16'd3950;
    t0_centi = 15'sd2500;
    in_idle_pct = 10;
    out_stall_pct = 47;
    words_sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, failed conversions, mixed groups
    send_group(12'd0, 1'b1);
    send_group(12'hFFF, 1'b1);
    send_group(12'hFFF, 1'b0);
    send_group(12'd1, 1'b1);
    send_group(12'd4094, 1'b1);
    send_word(12'hFFF, 1'b1);
    send_word(12'hFFF, 1'b1);
    send_word(12'hFFF, 1'b1);
    send_word(12'hFFF, 1'b1);
    send_word(12'hAAA, 1'b0);
    drain();

    // zero resistances, zero beta, extreme nominal temperatures
    set_config(20'd0, 20'd10000, 16'd0, -15'sd4000);
    send_group(12'd2048, 1'b1);
    drain();
    set_config(20'hFFFFF, 20'd0, 16'd1, 15'sd15000);
    send_group(12'd2048, 1'b1);
    drain();
    set_config(20'hFFFFF, 20'd1, 16'hFFFF, 15'sd15000);
    send_group(12'd4094, 1'b1);
    send_group(12'd1, 1'b1);
    drain();
    set_config(20'd1, 20'hFFFFF, 16'd1, -15'sd4000);
    send_group(12'd1, 1'b1);
    send_group(12'd4094, 1'b1);
    drain();

    // random phases with different calibrations and pacing
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        in_idle_pct = 47;
        out_stall_pct = 10;
      end else if (ph == 4) begin
        in_idle_pct = 0;
        out_stall_pct = 0;
      end
      if (ph == 5) set_config(20'd10000, 20'd10000, 16'd3950, 15'sd2500);
      else set_config(20'($urandom_range(20'hFFFFF, 1)), 20'($urandom_range(20'hFFFFF, 1)),
                      16'($urandom_range(16'hFFFF, 0)), 15'($urandom_range(19000) - 4000));
      random_words(250);
      drain();
    end

    $display("sent %0d sample words, checked %0d temperature words", words_sent,
             groups_seen);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
